// ===== hw/rtl/icl_pkg.sv =====
// ----------------------------------------------------------------------------
// icl_pkg
// Types, codes and priority helpers of the ICE check list engine.
// ----------------------------------------------------------------------------
package icl_pkg;

    localparam int MAX_CANDIDATES_DEF = 8;
    localparam int MAX_PAIRS_DEF      = 64;

    localparam logic [7:0]  PREF_HOST    = 8'd126;
    localparam logic [7:0]  PREF_SRFLX   = 8'd100;
    localparam logic [15:0] LOCAL_WEIGHT = 16'd65535;

    localparam logic [2:0] CMD_ADD_LOCAL  = 3'd0;
    localparam logic [2:0] CMD_ADD_REMOTE = 3'd1;
    localparam logic [2:0] CMD_FORM       = 3'd2;
    localparam logic [2:0] CMD_NEXT       = 3'd3;
    localparam logic [2:0] CMD_RESP       = 3'd4;
    localparam logic [2:0] CMD_FAIL       = 3'd5;
    localparam logic [2:0] CMD_RESTART    = 3'd6;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NO_WAIT  = 3'd2;
    localparam logic [2:0] ST_NO_MATCH = 3'd3;
    localparam logic [2:0] ST_NOT_NOM  = 3'd4;

    localparam logic [1:0] PH_GATHER    = 2'd0;
    localparam logic [1:0] PH_CHECKING  = 2'd1;
    localparam logic [1:0] PH_CONNECTED = 2'd2;
    localparam logic [1:0] PH_FAILED    = 2'd3;

    localparam logic [1:0] PROG_WAIT = 2'd0;
    localparam logic [1:0] PROG_BUSY = 2'd1;
    localparam logic [1:0] PROG_OK   = 2'd2;
    localparam logic [1:0] PROG_FAIL = 2'd3;

    // preference class: 0 host, 1 server reflexive, 2 other
    localparam logic [3:0] NUM_CLASS_PAIRS = 4'd9;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  cand_type;
        logic [31:0] cand_ip;
        logic [15:0] cand_port;
        logic [63:0] txid_high;
        logic [31:0] txid_low;
    } t_icl_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  session_phase;
        logic [5:0]  pair_slot;
        logic [62:0] slot_priority;
        logic [1:0]  local_type;
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic [1:0]  remote_type;
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic        nominated_now;
    } t_icl_rsp;

    typedef struct packed {
        logic [1:0]  cand_type;
        logic [31:0] cand_ip;
        logic [15:0] cand_port;
    } t_icl_cand;

    function automatic logic [1:0] type_class(input logic [1:0] t);
        logic [1:0] c;
        unique case (t)
            2'd0:    c = 2'd0;
            2'd1:    c = 2'd1;
            default: c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] cand_prio(input logic [1:0] t);
        logic [7:0] tp;
        unique case (t)
            2'd0:    tp = PREF_HOST;
            2'd1:    tp = PREF_SRFLX;
            default: tp = 8'd0;
        endcase
        return {tp, LOCAL_WEIGHT, 8'hFF};
    endfunction

    function automatic logic [62:0] pair_prio(input logic [31:0] g, input logic [31:0] d);
        logic [31:0] mn;
        logic [31:0] mx;
        logic [63:0] p;
        mn = (g < d) ? g : d;
        mx = (g < d) ? d : g;
        p  = {mn, 32'd0} | {31'd0, mx, 1'b0} | {63'd0, (g > d)};
        return p[62:0];
    endfunction

    // class pairs in descending pair priority: local class, remote class
    function automatic logic [3:0] class_pair(input logic [3:0] c);
        logic [3:0] v;
        unique case (c)
            4'd0:    v = {2'd0, 2'd0};
            4'd1:    v = {2'd0, 2'd1};
            4'd2:    v = {2'd1, 2'd0};
            4'd3:    v = {2'd1, 2'd1};
            4'd4:    v = {2'd0, 2'd2};
            4'd5:    v = {2'd2, 2'd0};
            4'd6:    v = {2'd1, 2'd2};
            4'd7:    v = {2'd2, 2'd1};
            default: v = {2'd2, 2'd2};
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ice_check_list_engine.sv =====
// ----------------------------------------------------------------------------
// ice_check_list_engine
// Connectivity-check list of one ICE session: candidate tables, pair
// forming in priority order, check dispatch and response matching.
//
//   channel   direction  signals                          payload
//   request   in         i_in_valid / o_in_stall          i_in  (t_icl_req)
//   result    out        o_out_valid / i_out_stall        o_out (t_icl_rsp)
//
// Add passes through a write state before its result; restart and unused
// commands report directly. Next check, response and failure scan the pair
// memory one entry a cycle through its single read port.
// Forming walks every local/remote combination once per class pair.
// Reset clears the fill counts, nomination and phase; no clearing pass.
// One request at a time; the next is taken while a result waits in o_out.
// ----------------------------------------------------------------------------
module ice_check_list_engine #(
    parameter int MAXC = icl_pkg::MAX_CANDIDATES_DEF,
    parameter int MAXP = icl_pkg::MAX_PAIRS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  icl_pkg::t_icl_req i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output icl_pkg::t_icl_rsp o_out
);
    import icl_pkg::*;

    localparam int CIW = (MAXC > 1) ? $clog2(MAXC) : 1;
    localparam int CCW = $clog2(MAXC + 1);
    localparam int PIW = (MAXP > 1) ? $clog2(MAXP) : 1;
    localparam int PCW = $clog2(MAXP + 1);
    localparam int FW  = CIW + CCW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FORM   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    typedef struct packed {
        logic [CIW-1:0] lidx;
        logic [CIW-1:0] ridx;
        logic [1:0]     prog;
        logic [63:0]    tag_hi;
        logic [31:0]    tag_lo;
    } t_pair;

    t_pair pair_mem [MAXP];
    t_pair r_prd;

    logic [2:0]     r_state, n_state;
    t_icl_req       r_req, n_req;
    logic [CCW-1:0] r_lfill, n_lfill;
    logic [CCW-1:0] r_rfill, n_rfill;
    logic [PCW-1:0] r_pfill, n_pfill;
    logic           r_chosen, n_chosen;
    logic [1:0]     r_phase, n_phase;
    logic [2:0]     r_st, n_st;
    logic           r_nom, n_nom;
    logic           r_hit, n_hit;
    logic [PIW-1:0] r_hidx, n_hidx;
    logic [CIW-1:0] r_hl, n_hl;
    logic [CIW-1:0] r_hr, n_hr;
    logic [1:0]     r_prog, n_prog;
    logic           r_pend, n_pend;
    logic [PCW-1:0] r_ra, n_ra;
    logic           r_dv, n_dv;
    logic [PIW-1:0] r_di, n_di;
    logic [3:0]     r_cls, n_cls;
    logic [CIW-1:0] r_fl, n_fl;
    logic [CIW-1:0] r_fr, n_fr;
    logic           r_ov, n_ov;
    t_icl_rsp       r_out, n_out;

    logic           pm_we, pm_re;
    logic [PIW-1:0] pm_waddr;
    t_pair          pm_wdata;
    logic           lt_we, rt_we, ct_re;
    t_icl_cand      cand_w;
    t_icl_cand      lt_rd, rt_rd;
    logic [1:0]     lt_cls, rt_cls;
    logic [FW-1:0]  fidx;
    logic [3:0]     cpair;
    logic           issue, tag_eq, cond, last_r, last_l;
    t_icl_rsp       rsp;

    assign cand_w = '{cand_type: r_req.cand_type, cand_ip: r_req.cand_ip,
                      cand_port: r_req.cand_port};

    icl_cand_table #(.DEPTH(MAXC), .IW(CIW)) u_local (
        .i_clk    (i_clk),
        .i_we     (lt_we),
        .i_waddr  (r_lfill[CIW-1:0]),
        .i_wdata  (cand_w),
        .i_re     (ct_re),
        .i_raddr  (r_hl),
        .o_rdata  (lt_rd),
        .i_taddr  (r_fl),
        .o_tclass (lt_cls)
    );

    icl_cand_table #(.DEPTH(MAXC), .IW(CIW)) u_remote (
        .i_clk    (i_clk),
        .i_we     (rt_we),
        .i_waddr  (r_rfill[CIW-1:0]),
        .i_wdata  (cand_w),
        .i_re     (ct_re),
        .i_raddr  (r_hr),
        .o_rdata  (rt_rd),
        .i_taddr  (r_fr),
        .o_tclass (rt_cls)
    );

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            pair_mem[pm_waddr] <= pm_wdata;
        end
        if (pm_re) begin
            r_prd <= pair_mem[r_ra[PIW-1:0]];
        end
    end

    assign fidx   = FW'(r_fl) * FW'(r_rfill) + FW'(r_fr);
    assign cpair  = class_pair(r_cls);
    assign issue  = (r_ra < r_pfill);
    assign tag_eq = (r_prd.tag_hi == r_req.txid_high) && (r_prd.tag_lo == r_req.txid_low);
    assign cond   = (r_req.command == CMD_NEXT) ? (r_prd.prog == PROG_WAIT)
                                                : (r_prd.prog == PROG_BUSY && tag_eq);
    assign last_r = (r_fr == CIW'(r_rfill - CCW'(1)));
    assign last_l = (r_fl == CIW'(r_lfill - CCW'(1)));

    always_comb begin
        rsp               = '0;
        rsp.status        = r_st;
        rsp.session_phase = r_phase;
        if (r_hit) begin
            rsp.pair_slot     = 6'(r_hidx);
            rsp.slot_priority = pair_prio(cand_prio(lt_rd.cand_type),
                                          cand_prio(rt_rd.cand_type));
            rsp.local_type    = lt_rd.cand_type;
            rsp.local_ip      = lt_rd.cand_ip;
            rsp.local_port    = lt_rd.cand_port;
            rsp.remote_type   = rt_rd.cand_type;
            rsp.remote_ip     = rt_rd.cand_ip;
            rsp.remote_port   = rt_rd.cand_port;
            rsp.nominated_now = r_nom;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_lfill  = r_lfill;
        n_rfill  = r_rfill;
        n_pfill  = r_pfill;
        n_chosen = r_chosen;
        n_phase  = r_phase;
        n_st     = r_st;
        n_nom    = r_nom;
        n_hit    = r_hit;
        n_hidx   = r_hidx;
        n_hl     = r_hl;
        n_hr     = r_hr;
        n_prog   = r_prog;
        n_pend   = r_pend;
        n_ra     = r_ra;
        n_dv     = r_dv;
        n_di     = r_di;
        n_cls    = r_cls;
        n_fl     = r_fl;
        n_fr     = r_fr;
        n_ov     = r_ov;
        n_out    = r_out;
        pm_we    = 1'b0;
        pm_re    = 1'b0;
        pm_waddr = r_hidx;
        pm_wdata = '{lidx: r_hl, ridx: r_hr, prog: r_prog,
                     tag_hi: r_req.txid_high, tag_lo: r_req.txid_low};
        lt_we    = 1'b0;
        rt_we    = 1'b0;
        ct_re    = 1'b0;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_st    = ST_DONE;
                    n_hit   = 1'b0;
                    n_nom   = 1'b0;
                    n_ra    = '0;
                    n_dv    = 1'b0;
                    n_pend  = 1'b0;
                    n_state = S_REPORT;
                    case (i_in.command)
                        CMD_ADD_LOCAL, CMD_ADD_REMOTE: n_state = S_WRITE;
                        CMD_FORM: begin
                            n_pfill = '0;
                            n_fl    = '0;
                            n_fr    = '0;
                            n_cls   = '0;
                            n_phase = PH_CHECKING;
                            if (r_lfill != '0 && r_rfill != '0) begin
                                n_state = S_FORM;
                            end
                        end
                        CMD_NEXT, CMD_RESP, CMD_FAIL: n_state = S_SCAN;
                        CMD_RESTART: begin
                            n_lfill  = '0;
                            n_rfill  = '0;
                            n_pfill  = '0;
                            n_chosen = 1'b0;
                            n_phase  = PH_GATHER;
                        end
                        default: ;
                    endcase
                end
            end
            S_FORM: begin
                if (lt_cls == cpair[3:2] && rt_cls == cpair[1:0] &&
                    32'(fidx) < 32'(MAXP)) begin
                    pm_we    = 1'b1;
                    pm_waddr = r_pfill[PIW-1:0];
                    pm_wdata = '{lidx: r_fl, ridx: r_fr, prog: PROG_WAIT,
                                 tag_hi: 64'd0, tag_lo: 32'd0};
                    n_pfill  = r_pfill + PCW'(1);
                end
                if (!last_r) begin
                    n_fr = r_fr + CIW'(1);
                end else begin
                    n_fr = '0;
                    if (!last_l) begin
                        n_fl = r_fl + CIW'(1);
                    end else begin
                        n_fl = '0;
                        if (r_cls == NUM_CLASS_PAIRS - 4'd1) begin
                            n_state = S_REPORT;
                        end else begin
                            n_cls = r_cls + 4'd1;
                        end
                    end
                end
            end
            S_SCAN: begin
                pm_re = issue;
                n_dv  = issue;
                n_di  = r_ra[PIW-1:0];
                if (issue) begin
                    n_ra = r_ra + PCW'(1);
                end
                if (r_dv) begin
                    if (cond && !r_hit) begin
                        n_hit  = 1'b1;
                        n_hidx = r_di;
                        n_hl   = r_prd.lidx;
                        n_hr   = r_prd.ridx;
                    end
                    if (r_prd.prog == PROG_WAIT ||
                        (r_prd.prog == PROG_BUSY &&
                         !(cond && !r_hit && r_req.command == CMD_FAIL))) begin
                        n_pend = 1'b1;
                    end
                end
                if (!issue && !r_dv) begin
                    n_state = r_hit ? S_WRITE : S_REPORT;
                    case (r_req.command)
                        CMD_NEXT: begin
                            if (r_hit) n_prog = PROG_BUSY;
                            else       n_st   = ST_NO_WAIT;
                        end
                        CMD_RESP: begin
                            if (!r_hit) begin
                                n_st = ST_NO_MATCH;
                            end else begin
                                n_prog = PROG_OK;
                                if (!r_chosen) begin
                                    n_chosen = 1'b1;
                                    n_phase  = PH_CONNECTED;
                                    n_nom    = 1'b1;
                                end else begin
                                    n_st = ST_NOT_NOM;
                                end
                            end
                        end
                        CMD_FAIL: begin
                            if (r_hit) n_prog = PROG_FAIL;
                            else       n_st   = ST_NO_MATCH;
                            if (!r_pend && !r_chosen) begin
                                n_phase = PH_FAILED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WRITE: begin
                n_state = S_REPORT;
                if (r_req.command == CMD_ADD_LOCAL) begin
                    if (r_lfill >= CCW'(MAXC)) begin
                        n_st = ST_FULL;
                    end else begin
                        lt_we   = 1'b1;
                        n_lfill = r_lfill + CCW'(1);
                    end
                end else if (r_req.command == CMD_ADD_REMOTE) begin
                    if (r_rfill >= CCW'(MAXC)) begin
                        n_st = ST_FULL;
                    end else begin
                        rt_we   = 1'b1;
                        n_rfill = r_rfill + CCW'(1);
                    end
                end else begin
                    pm_we = 1'b1;
                    ct_re = 1'b1;
                end
            end
            S_REPORT: begin
                if (!r_ov || !i_out_stall) begin
                    n_out   = rsp;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lfill  <= '0;
            r_rfill  <= '0;
            r_pfill  <= '0;
            r_chosen <= 1'b0;
            r_phase  <= PH_GATHER;
            r_ov     <= 1'b0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lfill  <= n_lfill;
            r_rfill  <= n_rfill;
            r_pfill  <= n_pfill;
            r_chosen <= n_chosen;
            r_phase  <= n_phase;
            r_ov     <= n_ov;
            r_dv     <= n_dv;
        end
        r_req  <= n_req;
        r_st   <= n_st;
        r_nom  <= n_nom;
        r_hit  <= n_hit;
        r_hidx <= n_hidx;
        r_hl   <= n_hl;
        r_hr   <= n_hr;
        r_prog <= n_prog;
        r_pend <= n_pend;
        r_ra   <= n_ra;
        r_di   <= n_di;
        r_cls  <= n_cls;
        r_fl   <= n_fl;
        r_fr   <= n_fr;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_pfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pfill <= PCW'(MAXP))
        else $error("pair fill above limit");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ra <= r_pfill))
        else $error("scan address past pair fill");

    a_nominate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.nominated_now) |->
            (o_out.session_phase == PH_CONNECTED && o_out.status == ST_DONE))
        else $error("nomination without connected phase");
`endif

endmodule

// ===== hw/rtl/icl_cand_table.sv =====
// ----------------------------------------------------------------------------
// icl_cand_table
// Candidate table: synchronous memory with registered read, plus a
// preference class per entry for pair forming.
// ----------------------------------------------------------------------------
module icl_cand_table #(
    parameter int DEPTH = icl_pkg::MAX_CANDIDATES_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IW-1:0]       i_waddr,
    input  icl_pkg::t_icl_cand  i_wdata,
    input  logic                i_re,
    input  logic [IW-1:0]       i_raddr,
    output icl_pkg::t_icl_cand  o_rdata,
    input  logic [IW-1:0]       i_taddr,
    output logic [1:0]          o_tclass
);
    import icl_pkg::*;

    t_icl_cand  mem [DEPTH];
    logic [1:0] r_class [DEPTH];
    t_icl_cand  r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr]     <= i_wdata;
            r_class[i_waddr] <= type_class(i_wdata.cand_type);
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata  = r_rdata;
    assign o_tclass = r_class[i_taddr];

endmodule

// ===== dv/ice_check_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// ice_check_list_engine_tb
// Drives candidate, pairing and check requests into the check list engine,
// predicts each result with a behavioral model of the session and compares
// every result field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ice_check_list_engine_tb;
    import icl_pkg::*;

    localparam int NCAND = 8;
    localparam int NPAIR = 64;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_icl_req i_in;
    logic     o_out_valid;
    logic     i_out_stall;
    t_icl_rsp o_out;

    ice_check_list_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // session model
    t_icl_cand   loc_tab [NCAND];
    t_icl_cand   rem_tab [NCAND];
    int          loc_cnt, rem_cnt, pair_cnt;
    int          pr_loc [NPAIR];
    int          pr_rem [NPAIR];
    logic [1:0]  pr_prog [NPAIR];
    logic [63:0] pr_thi [NPAIR];
    logic [31:0] pr_tlo [NPAIR];
    logic [62:0] pr_prio [NPAIR];
    bit          nominated;
    logic [1:0]  sess_phase;

    t_icl_req pending_reqs[$];
    t_icl_rsp expected_rsps[$];
    int       errors, n_rsp, n_nom;
    int       send_idle_pct, stall_pct;
    bit       hold_send;
    bit       in_taken;
    logic [63:0] issued_hi[$];
    logic [31:0] issued_lo[$];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] cand_weight(logic [1:0] t);
        logic [7:0] p;
        p = (t == 2'd0) ? 8'd126 : (t == 2'd1) ? 8'd100 : 8'd0;
        return {p, 16'hFFFF, 8'hFF};
    endfunction

    function automatic logic [62:0] combine_prio(logic [31:0] g, logic [31:0] d);
        logic [63:0] mn, mx;
        mn = (g < d) ? 64'(g) : 64'(d);
        mx = (g < d) ? 64'(d) : 64'(g);
        return 63'((mn << 32) | (mx << 1) | ((g > d) ? 64'd1 : 64'd0));
    endfunction

    function automatic void session_reset();
        loc_cnt = 0;
        rem_cnt = 0;
        pair_cnt = 0;
        nominated = 0;
        sess_phase = PH_GATHER;
    endfunction

    function automatic void fill_pair(ref t_icl_rsp r, input int i);
        r.pair_slot     = 6'(i);
        r.slot_priority = pr_prio[i];
        r.local_type    = loc_tab[pr_loc[i]].cand_type;
        r.local_ip      = loc_tab[pr_loc[i]].cand_ip;
        r.local_port    = loc_tab[pr_loc[i]].cand_port;
        r.remote_type   = rem_tab[pr_rem[i]].cand_type;
        r.remote_ip     = rem_tab[pr_rem[i]].cand_ip;
        r.remote_port   = rem_tab[pr_rem[i]].cand_port;
    endfunction

    function automatic void build_pairs();
        int j, sl, sr;
        logic [62:0] sp;
        pair_cnt = 0;
        for (int l = 0; l < loc_cnt && pair_cnt < NPAIR; l++) begin
            for (int r = 0; r < rem_cnt && pair_cnt < NPAIR; r++) begin
                pr_loc[pair_cnt]  = l;
                pr_rem[pair_cnt]  = r;
                pr_prog[pair_cnt] = PROG_WAIT;
                pr_prio[pair_cnt] = combine_prio(cand_weight(loc_tab[l].cand_type),
                                                 cand_weight(rem_tab[r].cand_type));
                pair_cnt++;
            end
        end
        for (int i = 1; i < pair_cnt; i++) begin
            j = i;
            sl = pr_loc[i];
            sr = pr_rem[i];
            sp = pr_prio[i];
            while (j > 0 && pr_prio[j-1] < sp) begin
                pr_loc[j]  = pr_loc[j-1];
                pr_rem[j]  = pr_rem[j-1];
                pr_prio[j] = pr_prio[j-1];
                j--;
            end
            pr_loc[j]  = sl;
            pr_rem[j]  = sr;
            pr_prio[j] = sp;
        end
        sess_phase = PH_CHECKING;
    endfunction

    function automatic int find_busy(logic [63:0] hi, logic [31:0] lo);
        for (int i = 0; i < pair_cnt; i++)
            if (pr_prog[i] == PROG_BUSY && pr_thi[i] == hi && pr_tlo[i] == lo)
                return i;
        return -1;
    endfunction

    function automatic t_icl_rsp predict_session(t_icl_req q);
        t_icl_rsp  r;
        t_icl_cand c;
        int m;
        bit busy;
        r = '0;
        c = '{cand_type: q.cand_type, cand_ip: q.cand_ip, cand_port: q.cand_port};
        case (q.command)
            CMD_ADD_LOCAL: begin
                if (loc_cnt >= NCAND) r.status = ST_FULL;
                else loc_tab[loc_cnt++] = c;
            end
            CMD_ADD_REMOTE: begin
                if (rem_cnt >= NCAND) r.status = ST_FULL;
                else rem_tab[rem_cnt++] = c;
            end
            CMD_FORM: build_pairs();
            CMD_NEXT: begin
                r.status = ST_NO_WAIT;
                for (int i = 0; i < pair_cnt; i++) begin
                    if (pr_prog[i] == PROG_WAIT) begin
                        pr_prog[i] = PROG_BUSY;
                        pr_thi[i] = q.txid_high;
                        pr_tlo[i] = q.txid_low;
                        fill_pair(r, i);
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            CMD_RESP: begin
                m = find_busy(q.txid_high, q.txid_low);
                if (m < 0) r.status = ST_NO_MATCH;
                else begin
                    pr_prog[m] = PROG_OK;
                    fill_pair(r, m);
                    if (!nominated) begin
                        nominated = 1;
                        sess_phase = PH_CONNECTED;
                        r.nominated_now = 1'b1;
                    end else r.status = ST_NOT_NOM;
                end
            end
            CMD_FAIL: begin
                m = find_busy(q.txid_high, q.txid_low);
                if (m < 0) r.status = ST_NO_MATCH;
                else begin
                    pr_prog[m] = PROG_FAIL;
                    fill_pair(r, m);
                end
                busy = 0;
                for (int i = 0; i < pair_cnt; i++)
                    if (pr_prog[i] == PROG_WAIT || pr_prog[i] == PROG_BUSY) busy = 1;
                if (!busy && !nominated) sess_phase = PH_FAILED;
            end
            CMD_RESTART: session_reset();
            default: ;
        endcase
        r.session_phase = sess_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (pending_reqs.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_in       <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_icl_rsp e;
        if (i_rst_n) begin
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken)
                expected_rsps.push_back(predict_session(i_in));
            if (o_out_valid && !i_out_stall) begin
                n_rsp++;
                if (o_out.nominated_now) n_nom++;
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_out.status), 64'd0);
                end else begin
                    e = expected_rsps.pop_front();
                    if (o_out.status != e.status)
                        report_mismatch("status", 64'(o_out.status), 64'(e.status));
                    if (o_out.session_phase != e.session_phase)
                        report_mismatch("session_phase", 64'(o_out.session_phase),
                                        64'(e.session_phase));
                    if (o_out.pair_slot != e.pair_slot)
                        report_mismatch("pair_slot", 64'(o_out.pair_slot),
                                        64'(e.pair_slot));
                    if (o_out.slot_priority != e.slot_priority)
                        report_mismatch("slot_priority", 64'(o_out.slot_priority),
                                        64'(e.slot_priority));
                    if (o_out.local_type != e.local_type)
                        report_mismatch("local_type", 64'(o_out.local_type),
                                        64'(e.local_type));
                    if (o_out.local_ip != e.local_ip)
                        report_mismatch("local_ip", 64'(o_out.local_ip), 64'(e.local_ip));
                    if (o_out.local_port != e.local_port)
                        report_mismatch("local_port", 64'(o_out.local_port),
                                        64'(e.local_port));
                    if (o_out.remote_type != e.remote_type)
                        report_mismatch("remote_type", 64'(o_out.remote_type),
                                        64'(e.remote_type));
                    if (o_out.remote_ip != e.remote_ip)
                        report_mismatch("remote_ip", 64'(o_out.remote_ip),
                                        64'(e.remote_ip));
                    if (o_out.remote_port != e.remote_port)
                        report_mismatch("remote_port", 64'(o_out.remote_port),
                                        64'(e.remote_port));
                    if (o_out.nominated_now != e.nominated_now)
                        report_mismatch("nominated_now", 64'(o_out.nominated_now),
                                        64'(e.nominated_now));
                end
            end
        end
    end

    function automatic t_icl_req make_req(logic [2:0] cmd);
        t_icl_req q;
        q.command   = cmd;
        q.cand_type = 2'($urandom_range(3));
        q.cand_ip   = $urandom;
        q.cand_port = 16'($urandom);
        q.txid_high = {$urandom, $urandom};
        q.txid_low  = $urandom;
        return q;
    endfunction

    function automatic t_icl_req make_check(logic [2:0] cmd, bit known);
        t_icl_req q;
        int k;
        q = make_req(cmd);
        if (known && issued_hi.size() > 0) begin
            k = $urandom_range(issued_hi.size() - 1);
            q.txid_high = issued_hi[k];
            q.txid_low  = issued_lo[k];
        end
        if (cmd == CMD_NEXT) begin
            issued_hi.push_back(q.txid_high);
            issued_lo.push_back(q.txid_low);
        end
        return q;
    endfunction

    // one session: restart, candidates, form, checks with outcomes
    task automatic queue_session(input int nl, input int nr, input int nchk);
        t_icl_req q;
        int c;
        issued_hi.delete();
        issued_lo.delete();
        pending_reqs.push_back(make_req(CMD_RESTART));
        for (int i = 0; i < nl; i++) pending_reqs.push_back(make_req(CMD_ADD_LOCAL));
        for (int i = 0; i < nr; i++) pending_reqs.push_back(make_req(CMD_ADD_REMOTE));
        pending_reqs.push_back(make_req(CMD_FORM));
        for (int i = 0; i < nchk; i++) begin
            c = $urandom_range(99);
            if (c < 40)      q = make_check(CMD_NEXT, 0);
            else if (c < 65) q = make_check(CMD_RESP, $urandom_range(9) > 0);
            else if (c < 88) q = make_check(CMD_FAIL, $urandom_range(9) > 0);
            else if (c < 91) q = make_req(CMD_FORM);
            else if (c < 94) q = make_req(CMD_UNUSED);
            else if (c < 97) q = make_req($urandom_range(1) ? CMD_ADD_LOCAL : CMD_ADD_REMOTE);
            else             q = make_req(3'($urandom_range(7)));
            pending_reqs.push_back(q);
        end
    endtask

    task automatic drain_queue();
        while (pending_reqs.size() > 0 || i_in_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        t_icl_req q;
        int nl, nr;
        errors = 0;
        n_rsp = 0;
        n_nom = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_send = 0;
        in_taken = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        session_reset();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty failure, overflow, extremes, all types
        pending_reqs.push_back(make_req(CMD_FAIL));
        pending_reqs.push_back(make_req(CMD_NEXT));
        for (int i = 0; i < 9; i++) begin
            q = make_req(CMD_ADD_LOCAL);
            q.cand_type = 2'(i % 4);
            q.cand_ip   = i[0] ? 32'hFFFF_FFFF : 32'h0;
            q.cand_port = i[0] ? 16'hFFFF : 16'h0;
            pending_reqs.push_back(q);
        end
        for (int i = 0; i < 8; i++) begin
            q = make_req(CMD_ADD_REMOTE);
            q.cand_type = 2'(3 - i % 4);
            pending_reqs.push_back(q);
        end
        pending_reqs.push_back(make_req(CMD_FORM));
        q = make_req(CMD_NEXT);
        q.txid_high = '1;
        q.txid_low  = '1;
        pending_reqs.push_back(q);
        q.command = CMD_RESP;
        pending_reqs.push_back(q);
        pending_reqs.push_back(q);
        pending_reqs.push_back(make_req(CMD_UNUSED));
        drain_queue();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                3: begin send_idle_pct = 35; stall_pct = 35; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int s = 0; s < 10; s++) begin
                nl = (s == 9) ? 8 : $urandom_range(1, 3);
                nr = (s == 9) ? 8 : $urandom_range(1, 3);
                queue_session(nl, nr, nl * nr + $urandom_range(4, 10));
                if (s == 4) begin
                    // sender holds off until the session is quiet
                    while (pending_reqs.size() > 0 || i_in_valid) @(posedge i_clk);
                    hold_send = 1;
                    while (expected_rsps.size() > 0) @(posedge i_clk);
                    @(negedge i_clk);
                    hold_send = 0;
                end
            end
            drain_queue();
        end

        $display("covered %0d results, %0d nominations, across five idle/stall mixes",
                 n_rsp, n_nom);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/icl_pkg.sv
hw/rtl/icl_cand_table.sv
hw/rtl/ice_check_list_engine.sv
dv/ice_check_list_engine_tb.sv
